// File: src/dmip_pkg.sv
package dmip_pkg;

    // Fixed widths of the encoder counters, gains and fields
    localparam int COUNTER_BITS   = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = 24;
    localparam int TARGET_W       = 16;
    localparam int SPEED_W        = 16;
    localparam int DUTY_W         = 9;
    localparam int ERR_W          = 18;
    localparam int ACC_W          = 48;
    localparam int SUM_W          = ACC_W + 2;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 5;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT = DUTY_W'(499);

    // rate = delta * 50 / 11; the divide by 11 is a reciprocal multiply,
    // exact for every operand below 2^21
    localparam int MUL_A_W            = 25;
    localparam int MUL_B_W            = 23;
    localparam int PROD_W             = MUL_A_W + MUL_B_W;
    localparam int RECIP_SHIFT        = 25;
    localparam logic [MUL_A_W-1:0] RECIP = MUL_A_W'(3050403);
    localparam int QUOT_W             = 18;

    localparam logic [GAIN_W-1:0]   KP_LEFT_RST      = GAIN_W'(98304);
    localparam logic [GAIN_W-1:0]   KI_LEFT_RST      = GAIN_W'(33);
    localparam logic [GAIN_W-1:0]   KD_LEFT_RST      = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]   KP_RIGHT_RST     = GAIN_W'(91750);
    localparam logic [GAIN_W-1:0]   KI_RIGHT_RST     = GAIN_W'(33);
    localparam logic [GAIN_W-1:0]   KD_RIGHT_RST     = GAIN_W'(65536);
    localparam logic [TARGET_W-1:0] TARGET_LEFT_RST  = TARGET_W'(30);
    localparam logic [TARGET_W-1:0] TARGET_RIGHT_RST = TARGET_W'(100);

    typedef enum logic [2:0] {
        REG_KP_LEFT      = 3'd0,
        REG_KI_LEFT      = 3'd1,
        REG_KD_LEFT      = 3'd2,
        REG_KP_RIGHT     = 3'd3,
        REG_KI_RIGHT     = 3'd4,
        REG_KD_RIGHT     = 3'd5,
        REG_TARGET_LEFT  = 3'd6,
        REG_TARGET_RIGHT = 3'd7
    } t_reg_idx;

    localparam logic MOTOR_LEFT  = 1'b0;
    localparam logic MOTOR_RIGHT = 1'b1;

    // Gains and targets, index 0 = left motor, 1 = right motor
    typedef struct packed {
        logic [1:0][GAIN_W-1:0]   kp;
        logic [1:0][GAIN_W-1:0]   ki;
        logic [1:0][GAIN_W-1:0]   kd;
        logic [1:0][TARGET_W-1:0] target;
    } t_gains;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_RATE,
        OP_DIFF,
        OP_MP,
        OP_MI,
        OP_MD,
        OP_ACC,
        OP_DRV,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_left;
        logic               forward_left;
        logic [DUTY_W-1:0]  duty_right;
        logic               forward_right;
        logic [SPEED_W-1:0] speed_left;
        logic [SPEED_W-1:0] speed_right;
    } t_result;

endpackage

// File: src/dmip_if.sv
interface dmip_in_if;
    import dmip_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COUNTER_BITS-1:0] count_left;
    logic [COUNTER_BITS-1:0] count_right;

    modport source (output valid, output count_left, output count_right, input ready);
    modport sink   (input valid, input count_left, input count_right, output ready);
endinterface

interface dmip_out_if;
    import dmip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DUTY_W-1:0]         duty_left;
    logic                      forward_left;
    logic [DUTY_W-1:0]         duty_right;
    logic                      forward_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;

    modport source (output valid, output duty_left, output forward_left,
                    output duty_right, output forward_right,
                    output speed_left, output speed_right, input ready);
    modport sink   (input valid, input duty_left, input forward_left,
                    input duty_right, input forward_right,
                    input speed_left, input speed_right, output ready);
endinterface

// File: src/dmip_regs.sv
module dmip_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dmip_pkg::ADDR_W-1:0]    paddr,
    input  logic [dmip_pkg::DATA_W-1:0]    pwdata,
    output logic [dmip_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output dmip_pkg::t_gains               o_gains
);
    import dmip_pkg::*;

    t_gains   r_gains;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_gains = r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp[0]     <= KP_LEFT_RST;
            r_gains.ki[0]     <= KI_LEFT_RST;
            r_gains.kd[0]     <= KD_LEFT_RST;
            r_gains.kp[1]     <= KP_RIGHT_RST;
            r_gains.ki[1]     <= KI_RIGHT_RST;
            r_gains.kd[1]     <= KD_RIGHT_RST;
            r_gains.target[0] <= TARGET_LEFT_RST;
            r_gains.target[1] <= TARGET_RIGHT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_KP_LEFT:      r_gains.kp[0]     <= pwdata[GAIN_W-1:0];
                REG_KI_LEFT:      r_gains.ki[0]     <= pwdata[GAIN_W-1:0];
                REG_KD_LEFT:      r_gains.kd[0]     <= pwdata[GAIN_W-1:0];
                REG_KP_RIGHT:     r_gains.kp[1]     <= pwdata[GAIN_W-1:0];
                REG_KI_RIGHT:     r_gains.ki[1]     <= pwdata[GAIN_W-1:0];
                REG_KD_RIGHT:     r_gains.kd[1]     <= pwdata[GAIN_W-1:0];
                REG_TARGET_LEFT:  r_gains.target[0] <= pwdata[TARGET_W-1:0];
                REG_TARGET_RIGHT: r_gains.target[1] <= pwdata[TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KP_LEFT:      prdata = DATA_W'(r_gains.kp[0]);
            REG_KI_LEFT:      prdata = DATA_W'(r_gains.ki[0]);
            REG_KD_LEFT:      prdata = DATA_W'(r_gains.kd[0]);
            REG_KP_RIGHT:     prdata = DATA_W'(r_gains.kp[1]);
            REG_KI_RIGHT:     prdata = DATA_W'(r_gains.ki[1]);
            REG_KD_RIGHT:     prdata = DATA_W'(r_gains.kd[1]);
            REG_TARGET_LEFT:  prdata = DATA_W'(r_gains.target[0]);
            REG_TARGET_RIGHT: prdata = DATA_W'(r_gains.target[1]);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: src/dmip_ctrl.sv
module dmip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output dmip_pkg::t_cmd o_cmd
);
    import dmip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RATE,
        S_DIFF,
        S_MP,
        S_MI,
        S_MD,
        S_ACC,
        S_DRV,
        S_PUSH
    } t_state;

    t_state r_state;
    logic   r_sel;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_DIV:   o_cmd.op = OP_DIV;
            S_RATE:  o_cmd.op = OP_RATE;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_MP:    o_cmd.op = OP_MP;
            S_MI:    o_cmd.op = OP_MI;
            S_MD:    o_cmd.op = OP_MD;
            S_ACC:   o_cmd.op = OP_ACC;
            S_DRV:   o_cmd.op = OP_DRV;
            S_PUSH:  o_cmd.op = out_free ? OP_PUSH : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= MOTOR_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            // Set on a push, otherwise drop once the result is taken
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= MOTOR_LEFT;
                        r_state <= S_DIV;
                    end
                end
                S_DIV:  r_state <= S_RATE;
                S_RATE: r_state <= S_DIFF;
                S_DIFF: r_state <= S_MP;
                S_MP:   r_state <= S_MI;
                S_MI:   r_state <= S_MD;
                S_MD:   r_state <= S_ACC;
                S_ACC:  r_state <= S_DRV;
                S_DRV: begin
                    if (r_sel == MOTOR_LEFT) begin
                        r_sel   <= MOTOR_RIGHT;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/dmip_datapath.sv
module dmip_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dmip_pkg::t_cmd                    i_cmd,
    input  dmip_pkg::t_gains                  i_gains,
    input  logic [dmip_pkg::COUNTER_BITS-1:0] i_count_left,
    input  logic [dmip_pkg::COUNTER_BITS-1:0] i_count_right,
    output dmip_pkg::t_result                 o_result
);
    import dmip_pkg::*;

    localparam int MAG_W = COUNTER_BITS + 1;

    logic [COUNTER_BITS-1:0]  r_cnt  [2];
    logic [COUNTER_BITS-1:0]  r_last [2];
    logic signed [ERR_W-1:0]  r_e1   [2];
    logic signed [ERR_W-1:0]  r_e2   [2];
    logic signed [ACC_W-1:0]  r_acc  [2];
    logic [DUTY_W-1:0]        r_duty [2];
    logic                     r_fwd  [2];
    logic [SPEED_W-1:0]       r_spd  [2];

    logic                      r_neg;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SPEED_W-1:0] r_rate;
    logic signed [ERR_W-1:0]   r_e;
    logic signed [ERR_W:0]     r_dp;
    logic signed [ERR_W:0]     r_di;
    logic signed [ERR_W+1:0]   r_dd;
    logic signed [SUM_W-1:0]   r_sum;
    t_result                   r_res;

    logic                      sel;
    logic [COUNTER_BITS-1:0]   delta;
    logic [MAG_W-1:0]          delta_mag;
    logic [MUL_B_W-1:0]        m50;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [QUOT_W-1:0]         quot;
    logic signed [SPEED_W-1:0] rate_sat;
    logic signed [ERR_W-1:0]   e_now;
    logic signed [ERR_W+1:0]   e_w;
    logic signed [ERR_W+1:0]   e1_w;
    logic signed [ERR_W+1:0]   e2_w;
    logic signed [SUM_W-1:0]   prod_w;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [ACC_W-1:0]   acc_cur;
    logic [ACC_W-1:0]          acc_mag;
    logic [ACC_W-GAIN_FRAC_BITS-1:0] drive_int;
    logic [DUTY_W-1:0]         duty_clamp;

    assign sel = i_cmd.sel;

    // Wrapped count change and its scaled magnitude, |delta| * 50
    assign delta     = r_cnt[sel] - r_last[sel];
    assign delta_mag = delta[COUNTER_BITS-1]
                     ? MAG_W'(-{1'b1, delta})
                     : {1'b0, delta};
    assign m50 = (MUL_B_W'(delta_mag) << 5) + (MUL_B_W'(delta_mag) << 4)
               + (MUL_B_W'(delta_mag) << 1);

    always_comb begin
        case (i_cmd.op)
            OP_DIV: begin
                mul_a = RECIP;
                mul_b = m50;
            end
            OP_MP: begin
                mul_a = {1'b0, i_gains.kp[sel]};
                mul_b = MUL_B_W'(r_dp);
            end
            OP_MI: begin
                mul_a = {1'b0, i_gains.ki[sel]};
                mul_b = MUL_B_W'(r_di);
            end
            default: begin
                mul_a = {1'b0, i_gains.kd[sel]};
                mul_b = MUL_B_W'(r_dd);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Truncated quotient, then signed saturation to 16 bits
    assign quot = r_prod[RECIP_SHIFT +: QUOT_W];
    always_comb begin
        if (r_neg) begin
            rate_sat = (quot > QUOT_W'(32768)) ? SPEED_W'(16'h8000)
                                                : SPEED_W'(-quot);
        end else begin
            rate_sat = (quot > QUOT_W'(32767)) ? SPEED_W'(16'h7fff)
                                                : SPEED_W'(quot);
        end
    end

    assign e_now = ERR_W'($signed(i_gains.target[sel])) - ERR_W'(r_rate);
    assign e_w   = (ERR_W+2)'(e_now);
    assign e1_w  = (ERR_W+2)'(r_e1[sel]);
    assign e2_w  = (ERR_W+2)'(r_e2[sel]);

    assign prod_w  = SUM_W'(r_prod);
    assign acc_sum = r_sum + prod_w;
    always_comb begin
        if (acc_sum[SUM_W-1:ACC_W-1] == '0 || acc_sum[SUM_W-1:ACC_W-1] == '1) begin
            acc_sat = acc_sum[ACC_W-1:0];
        end else if (acc_sum[SUM_W-1]) begin
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Drive magnitude: integer part of |acc|, clamped to the duty limit
    assign acc_cur    = r_acc[sel];
    assign acc_mag    = acc_cur[ACC_W-1] ? ACC_W'(-acc_cur) : ACC_W'(acc_cur);
    assign drive_int  = acc_mag[ACC_W-1:GAIN_FRAC_BITS];
    assign duty_clamp = (drive_int > (ACC_W-GAIN_FRAC_BITS)'(DUTY_LIMIT))
                      ? DUTY_LIMIT
                      : drive_int[DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < 2; m++) begin
                r_last[m] <= '0;
                r_e1[m]   <= '0;
                r_e2[m]   <= '0;
                r_acc[m]  <= '0;
            end
        end else if (i_cmd.op == OP_ACC) begin
            r_acc[sel]  <= acc_sat;
            r_e2[sel]   <= r_e1[sel];
            r_e1[sel]   <= r_e;
            r_last[sel] <= r_cnt[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cnt[0] <= i_count_left;
                r_cnt[1] <= i_count_right;
            end
            OP_DIV: begin
                r_neg  <= delta[COUNTER_BITS-1];
                r_prod <= mul_p;
            end
            OP_RATE: begin
                r_rate     <= rate_sat;
                r_spd[sel] <= rate_sat;
            end
            OP_DIFF: begin
                r_e   <= e_now;
                r_dp  <= (ERR_W+1)'(e_w - e1_w);
                r_di  <= (ERR_W+1)'(e_w + e1_w);
                r_dd  <= e_w - (e1_w <<< 1) + e2_w;
                r_sum <= SUM_W'(r_acc[sel]);
            end
            OP_MP: begin
                r_prod <= mul_p;
            end
            OP_MI, OP_MD: begin
                r_sum  <= acc_sum;
                r_prod <= mul_p;
            end
            OP_DRV: begin
                r_duty[sel] <= duty_clamp;
                r_fwd[sel]  <= !acc_cur[ACC_W-1] && (duty_clamp != '0);
            end
            OP_PUSH: begin
                r_res.duty_left     <= r_duty[0];
                r_res.forward_left  <= r_fwd[0];
                r_res.duty_right    <= r_duty[1];
                r_res.forward_right <= r_fwd[1];
                r_res.speed_left    <= r_spd[0];
                r_res.speed_right   <= r_spd[1];
            end
            default: ;
        endcase
    end

    assign o_result = r_res;

endmodule

// File: src/dual_motor_incremental_pid.sv
// Channel     Dir  Handshake            Payload
// i_cnt       in   valid / ready        count_left, count_right (16b each)
// o_res       out  valid / ready        duty_*, forward_*, speed_* per motor
// APB (p*)    in   psel,penable,pwrite  8 x 32b registers at 4*i, pready tied high
//
// A transaction runs through one accept step, eight sequencer steps per
// motor through the single shared 25x23 multiplier (rate divide, rate,
// differences, P, I, D, accumulate, drive), and one push into the output
// register, after which the result turns valid. The next transaction is
// accepted in the cycle after the push, while the result may still wait for
// o_res.ready.
// Reset (synchronous, active low) clears counts, errors and accumulators and
// loads the default gains; a stalled output holds the sequencer at its push step.
module dual_motor_incremental_pid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dmip_in_if.sink                       i_cnt,
    dmip_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dmip_pkg::ADDR_W-1:0]   paddr,
    input  logic [dmip_pkg::DATA_W-1:0]   pwdata,
    output logic [dmip_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dmip_pkg::*;

    t_gains  gains;
    t_cmd    cmd;
    t_result result;

    // Gain and target registers behind the APB port
    dmip_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    // Sequencer: steps left motor then right motor, then pushes the result
    dmip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cnt.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_cnt.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    // Shared multiplier, per-motor state and the output register
    dmip_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_gains       (gains),
        .i_count_left  (i_cnt.count_left),
        .i_count_right (i_cnt.count_right),
        .o_result      (result)
    );

    // Drive the result channel straight from the output register
    assign o_res.duty_left     = result.duty_left;
    assign o_res.forward_left  = result.forward_left;
    assign o_res.duty_right    = result.duty_right;
    assign o_res.forward_right = result.forward_right;
    assign o_res.speed_left    = $signed(result.speed_left);
    assign o_res.speed_right   = $signed(result.speed_right);

    // Accepting a transaction starts the sequencer, so ready must drop
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cnt.valid && i_cnt.ready) |=> !i_cnt.ready)
        else $error("input still ready after accept");

    // Clamp holds on both motors
    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.duty_left <= DUTY_LIMIT && o_res.duty_right <= DUTY_LIMIT))
        else $error("duty above limit");

    // Forward drive always carries a nonzero duty
    a_forward_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((!o_res.forward_left || o_res.duty_left != '0) &&
                         (!o_res.forward_right || o_res.duty_right != '0)))
        else $error("forward set with zero duty");

    // No new transaction is taken while a result is being pushed out
    a_no_accept_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_PUSH) |-> !i_cnt.ready)
        else $error("input ready during push");

endmodule
